>>> rtl/assert_macros.svh
// Assertion macros shared by the list manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DLLM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list manager assertion failed");

// Next-cycle implication, disabled during reset.
`define DLLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list manager assertion failed");

`endif

>>> rtl/dllm_pkg.sv
// Types and constants of the doubly linked list manager.
package dllm_pkg;

   localparam int NODE_W  = 6;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_HEAD   = 2'd0,
      OP_TAIL   = 2'd1,
      OP_AFTER  = 2'd2,
      OP_REMOVE = 2'd3
   } req_op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_W1   = 3'b010,
      ST_W2   = 3'b100
   } state_type;

endpackage

>>> rtl/dllm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dllm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/doubly_linked_list_manager_unit.sv
// Top level of the doubly linked list manager.
//
// One request channel (req_*) and one response channel (rsp_*), both valid/ready;
// a transfer happens on an edge where valid and ready are both high.
// Each request inserts a node at the head, at the tail, after an anchor, or
// removes it; the response carries the node and the new head, tail and count.
// Links live in two RAMs (next and previous), one write port each, read data
// registered. The accept edge issues the link reads; ST_W1 applies the first
// write to each RAM and updates head, tail and count, and ST_W2 applies the
// second write to each RAM. The next request is accepted in ST_IDLE or during
// ST_W2, with forwarding of the pending write into its read, so a new request
// is taken while the last one's second write is applied. The single write
// port of each link RAM keeps two requests from overlapping any further.
// The response register is loaded when ST_W1 applies the first writes.
// Reset empties the list (head, tail null, count zero); link RAM contents
// stay undefined and are written before use. A stalled receiver holds the
// response register; one more request is accepted and then holds in its
// first cycle until the response register frees.
module doubly_linked_list_manager_unit #(
   parameter int NODES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [5:0] req_node_index,
   input  logic [5:0] req_anchor_index,
   input  logic       req_anchor_present,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_handled_node,
   output logic [5:0] rsp_head_index,
   output logic       rsp_head_present,
   output logic [5:0] rsp_tail_index,
   output logic       rsp_tail_present,
   output logic [6:0] rsp_node_count
);

   `include "assert_macros.svh"

   localparam int LINK_W  = $clog2(NODES + 1);
   localparam int ADDR_W  = $clog2(NODES);
   localparam int NODE_W  = dllm_pkg::NODE_W;
   localparam int COUNT_W = dllm_pkg::COUNT_W;

   localparam logic [LINK_W-1:0] NULL_LINK = '0;
   localparam logic [LINK_W-1:0] ONE_LINK  = LINK_W'(1);
   localparam logic [LINK_W-1:0] MAX_COUNT = LINK_W'(NODES);

   dllm_pkg::state_type  state_ff, state_in;
   dllm_pkg::req_op_type op_ff, op_eff, req_op;

   logic [NODE_W-1:0] node_ff;
   logic [LINK_W-1:0] nlink_ff, alink_ff;
   logic              act_ff;
   logic              fwdn_ff, fwdp_ff;
   logic [LINK_W-1:0] fwdn_data_ff, fwdp_data_ff;
   logic [LINK_W-1:0] head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in;
   logic              nw2_en_ff, nw2_en_in, pw2_en_ff, pw2_en_in;
   logic [LINK_W-1:0] nw2_at_ff, nw2_at_in, nw2_val_ff, nw2_val_in;
   logic [LINK_W-1:0] pw2_at_ff, pw2_at_in, pw2_val_ff, pw2_val_in;

   logic              rsp_valid_ff;
   logic [NODE_W-1:0] rsp_node_ff, rsp_head_ff, rsp_tail_ff;
   logic              rsp_hp_ff, rsp_tp_ff;
   logic [COUNT_W-1:0] rsp_cnt_ff;

   logic              req_go, w1_go, in_pool;
   logic [LINK_W-1:0] req_alink;
   logic              nw1_en, pw1_en;
   logic [LINK_W-1:0] nw1_at, nw1_val, pw1_at, pw1_val;
   logic [LINK_W-1:0] nn_link, pp_link;

   logic              next_we, prev_we;
   logic [LINK_W-1:0] next_wlink, prev_wlink;
   logic [ADDR_W-1:0] next_waddr, prev_waddr, next_raddr, prev_raddr;
   logic [LINK_W-1:0] next_wdata, prev_wdata, next_rdata, prev_rdata;

   assign req_op    = dllm_pkg::req_op_type'(req_type);
   assign req_ready = !reset &&
                      ((state_ff == dllm_pkg::ST_IDLE) || (state_ff == dllm_pkg::ST_W2));
   assign req_go    = req_valid && req_ready;
   assign w1_go     = (state_ff == dllm_pkg::ST_W1) && (!rsp_valid_ff || rsp_ready);
   assign in_pool   = 32'(req_node_index) < NODES;
   assign req_alink = (req_anchor_present && (32'(req_anchor_index) < NODES)) ?
                      LINK_W'(req_anchor_index) + ONE_LINK : NULL_LINK;

   assign next_raddr = (req_op == dllm_pkg::OP_AFTER) ? ADDR_W'(req_anchor_index) :
                                                        ADDR_W'(req_node_index);
   assign prev_raddr = ADDR_W'(req_node_index);

   assign nn_link = fwdn_ff ? fwdn_data_ff : next_rdata;
   assign pp_link = fwdp_ff ? fwdp_data_ff : prev_rdata;

   always_comb begin
      op_eff = op_ff;
      if (op_ff == dllm_pkg::OP_AFTER && (head_ff == NULL_LINK || alink_ff == NULL_LINK)) begin
         op_eff = dllm_pkg::OP_HEAD;
      end
      nw1_en = 1'b0; nw1_at = nlink_ff; nw1_val = NULL_LINK;
      pw1_en = 1'b0; pw1_at = nlink_ff; pw1_val = NULL_LINK;
      nw2_en_in = 1'b0; nw2_at_in = nlink_ff; nw2_val_in = NULL_LINK;
      pw2_en_in = 1'b0; pw2_at_in = nlink_ff; pw2_val_in = NULL_LINK;
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (act_ff) begin
         unique case (op_eff)
            dllm_pkg::OP_HEAD: begin
               nw1_en = 1'b1; nw1_val = head_ff;
               pw1_en = 1'b1;
               pw2_en_in = head_ff != NULL_LINK; pw2_at_in = head_ff; pw2_val_in = nlink_ff;
               head_in = nlink_ff;
               tail_in = (head_ff == NULL_LINK) ? nlink_ff : tail_ff;
            end
            dllm_pkg::OP_TAIL: begin
               nw1_en = 1'b1;
               pw1_en = 1'b1; pw1_val = tail_ff;
               nw2_en_in = (head_ff != NULL_LINK) && (tail_ff != NULL_LINK);
               nw2_at_in = tail_ff; nw2_val_in = nlink_ff;
               head_in = (head_ff == NULL_LINK) ? nlink_ff : head_ff;
               tail_in = nlink_ff;
            end
            dllm_pkg::OP_AFTER: begin
               nw1_en = 1'b1; nw1_val = nn_link;
               pw1_en = 1'b1; pw1_val = alink_ff;
               nw2_en_in = 1'b1; nw2_at_in = alink_ff; nw2_val_in = nlink_ff;
               pw2_en_in = nn_link != NULL_LINK; pw2_at_in = nn_link; pw2_val_in = nlink_ff;
               tail_in = (alink_ff == tail_ff) ? nlink_ff : tail_ff;
            end
            dllm_pkg::OP_REMOVE: begin
               nw1_en = pp_link != NULL_LINK; nw1_at = pp_link; nw1_val = nn_link;
               pw1_en = nn_link != NULL_LINK; pw1_at = nn_link; pw1_val = pp_link;
               nw2_en_in = 1'b1;
               pw2_en_in = 1'b1;
               head_in = (nlink_ff == head_ff) ? nn_link : head_ff;
               tail_in = (nlink_ff == tail_ff) ? pp_link : tail_ff;
            end
            default: begin
            end
         endcase
         if (op_eff == dllm_pkg::OP_REMOVE) begin
            cnt_in = (cnt_ff != NULL_LINK) ? cnt_ff - ONE_LINK : cnt_ff;
         end else begin
            cnt_in = (cnt_ff != MAX_COUNT) ? cnt_ff + ONE_LINK : cnt_ff;
         end
      end
   end

   always_comb begin
      next_we = 1'b0; next_wlink = nw1_at; next_wdata = nw1_val;
      prev_we = 1'b0; prev_wlink = pw1_at; prev_wdata = pw1_val;
      if (w1_go) begin
         next_we = nw1_en;
         prev_we = pw1_en;
      end else if (state_ff == dllm_pkg::ST_W2) begin
         next_we = nw2_en_ff; next_wlink = nw2_at_ff; next_wdata = nw2_val_ff;
         prev_we = pw2_en_ff; prev_wlink = pw2_at_ff; prev_wdata = pw2_val_ff;
      end
   end

   assign next_waddr = ADDR_W'(next_wlink - ONE_LINK);
   assign prev_waddr = ADDR_W'(prev_wlink - ONE_LINK);

   dllm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (req_go),
      .rd_addr (next_raddr),
      .rd_data (next_rdata)
   );

   dllm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (req_go),
      .rd_addr (prev_raddr),
      .rd_data (prev_rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dllm_pkg::ST_IDLE: if (req_go) state_in = dllm_pkg::ST_W1;
         dllm_pkg::ST_W1:   if (w1_go)  state_in = dllm_pkg::ST_W2;
         dllm_pkg::ST_W2:   state_in = req_go ? dllm_pkg::ST_W1 : dllm_pkg::ST_IDLE;
         default:           state_in = dllm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dllm_pkg::ST_IDLE;
         head_ff      <= NULL_LINK;
         tail_ff      <= NULL_LINK;
         cnt_ff       <= NULL_LINK;
         nw2_en_ff    <= 1'b0;
         pw2_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (w1_go) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            cnt_ff       <= cnt_in;
            nw2_en_ff    <= nw2_en_in;
            pw2_en_ff    <= pw2_en_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         op_ff        <= req_op;
         node_ff      <= req_node_index;
         nlink_ff     <= LINK_W'(req_node_index) + ONE_LINK;
         alink_ff     <= req_alink;
         act_ff       <= in_pool;
         fwdn_ff      <= next_we && (next_waddr == next_raddr);
         fwdn_data_ff <= next_wdata;
         fwdp_ff      <= prev_we && (prev_waddr == prev_raddr);
         fwdp_data_ff <= prev_wdata;
      end
      if (w1_go) begin
         nw2_at_ff   <= nw2_at_in;
         nw2_val_ff  <= nw2_val_in;
         pw2_at_ff   <= pw2_at_in;
         pw2_val_ff  <= pw2_val_in;
         rsp_node_ff <= node_ff;
         rsp_hp_ff   <= head_in != NULL_LINK;
         rsp_tp_ff   <= tail_in != NULL_LINK;
         rsp_head_ff <= (head_in != NULL_LINK) ? NODE_W'(head_in - ONE_LINK) : '0;
         rsp_tail_ff <= (tail_in != NULL_LINK) ? NODE_W'(tail_in - ONE_LINK) : '0;
         rsp_cnt_ff  <= COUNT_W'(cnt_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_handled_node = rsp_node_ff;
   assign rsp_head_index   = rsp_head_ff;
   assign rsp_head_present = rsp_hp_ff;
   assign rsp_tail_index   = rsp_tail_ff;
   assign rsp_tail_present = rsp_tp_ff;
   assign rsp_node_count   = rsp_cnt_ff;

   `DLLM_ASSERT_NOW(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `DLLM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, cnt_ff <= MAX_COUNT)
   `DLLM_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == dllm_pkg::ST_IDLE,
      !next_we && !prev_we)
   `DLLM_ASSERT_NEXT(a_w1_hold, clock, reset,
      state_ff == dllm_pkg::ST_W1 && rsp_valid_ff && !rsp_ready,
      state_ff == dllm_pkg::ST_W1 && rsp_valid_ff)
   `DLLM_ASSERT_NEXT(a_w1_to_w2, clock, reset, w1_go,
      state_ff == dllm_pkg::ST_W2 && rsp_valid_ff)

endmodule
